@@ rtl/sdlru_pkg.sv @@
// Shared types, codes and constants of the stream-demoting LRU replacement block.
// No dependencies; every file of the block but sdlru_stream_if imports this package.
package sdlru_pkg;

	localparam int DEF_NUM_SETS   = 64;
	localparam int DEF_NUM_WAYS   = 8;
	localparam int DEF_STAMP_BITS = 32;

	localparam int REQ_TYPE_W  = 2;
	localparam int SET_IN_W    = 6;
	localparam int WAY_IN_W    = 3;
	localparam int VICTIM_W    = 3;
	localparam int EVENT_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FILL_DEMOTE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REUSE_PROMOTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_UNLEARN  = 2'd2;

	localparam logic [REQ_TYPE_W-1:0] REQ_TOUCH = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_FILL  = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_INVAL = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd3;

	typedef enum logic [EVENT_W-1:0] {
		EV_PLAIN         = 2'd0,
		EV_DEMOTED_FILL  = 2'd1,
		EV_DEMOTED_TOUCH = 2'd2,
		EV_PROMOTED      = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		OP_TOUCH,
		OP_FILL,
		OP_INVAL,
		OP_QUERY,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_TREE
	} back_state_t;

	typedef struct packed {
		logic fill_demote_en;
		logic reuse_promote_en;
		logic page_unlearn_en;
	} cfg_t;

	typedef struct packed {
		op_t  op;
		logic is_stream;
	} cmd_ctl_t;

	localparam int CTL_W = $bits(cmd_ctl_t);

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [SET_IN_W-1:0]   set_index;
		logic [WAY_IN_W-1:0]   way;
		logic                  is_stream;
	} req_t;

	typedef struct packed {
		logic [VICTIM_W-1:0] victim_way;
		logic                promote_page;
		logic [EVENT_W-1:0]  event_res;
	} res_t;

endpackage

@@ rtl/sdlru_stream_if.sv @@
// Valid/ready channel carrying one payload per transaction.
// The payload type is supplied at instantiation, normally a struct from sdlru_pkg.
interface sdlru_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sdlru_front.sv @@
// Front end: accepts request transactions and classifies them into queue commands.
// Depends on sdlru_pkg and sdlru_stream_if.
module sdlru_front #(
	parameter int NUM_SETS = sdlru_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS = sdlru_pkg::DEF_NUM_WAYS,
	parameter int SET_W    = 1,
	parameter int WAY_W    = 1
) (
	sdlru_stream_if.sink          req,
	input  logic                  queue_full,
	input  logic                  init_busy,
	output logic                  push,
	output sdlru_pkg::cmd_ctl_t   cmd_ctl,
	output logic [SET_W-1:0]      cmd_set,
	output logic [WAY_W-1:0]      cmd_way
);
	import sdlru_pkg::*;

	localparam int SET_SPAN = 1 << SET_IN_W;
	localparam int WX       = WAY_W + WAY_IN_W;

	logic [SET_W-1:0] set_lut [SET_SPAN];
	logic             way_ok;
	logic [WX-1:0]    way_ext;

	for (genvar g = 0; g < SET_SPAN; g++) begin : g_set_lut
		assign set_lut[g] = SET_W'(g % NUM_SETS);
	end

	assign req.ready = !queue_full && !init_busy;
	assign push      = req.valid && req.ready;
	assign way_ok    = 32'(req.data.way) < 32'(NUM_WAYS);
	assign way_ext   = WX'(req.data.way);
	assign cmd_way   = way_ext[WAY_W-1:0];
	assign cmd_set   = set_lut[req.data.set_index];

	always_comb begin
		cmd_ctl.is_stream = req.data.is_stream;
		case (req.data.req_type)
			REQ_QUERY: cmd_ctl.op = OP_QUERY;
			REQ_TOUCH: cmd_ctl.op = way_ok ? OP_TOUCH : OP_NOP;
			REQ_FILL:  cmd_ctl.op = way_ok ? OP_FILL : OP_NOP;
			REQ_INVAL: cmd_ctl.op = way_ok ? OP_INVAL : OP_NOP;
			default:   cmd_ctl.op = OP_NOP;
		endcase
	end
endmodule

@@ rtl/sdlru_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on sdlru_pkg for its depth.
module sdlru_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);
	import sdlru_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

@@ rtl/sdlru_back.sv @@
// Back end: set memory, access counter, victim search tree and result register.
// Depends on sdlru_pkg and sdlru_stream_if.
module sdlru_back #(
	parameter int NUM_SETS   = sdlru_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS   = sdlru_pkg::DEF_NUM_WAYS,
	parameter int STAMP_BITS = sdlru_pkg::DEF_STAMP_BITS,
	parameter int SET_W      = 1,
	parameter int WAY_W      = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdlru_pkg::cfg_t     cfg,
	input  logic                q_empty,
	input  sdlru_pkg::cmd_ctl_t q_ctl,
	input  logic [SET_W-1:0]    q_set,
	input  logic [WAY_W-1:0]    q_way,
	output logic                pop,
	output logic                init_busy,
	sdlru_stream_if.source      res
);
	import sdlru_pkg::*;

	localparam int P     = 1 << WAY_W;
	localparam int HALF  = P / 2;
	localparam int LVLS  = WAY_W;
	localparam int LVL_W = $clog2(LVLS + 1);
	localparam int WX    = WAY_W + VICTIM_W;

	logic [NUM_WAYS-1:0][STAMP_BITS:0] mem_q [NUM_SETS];
	logic [NUM_WAYS-1:0][STAMP_BITS:0] rd_row_q;
	logic [NUM_WAYS-1:0][STAMP_BITS:0] upd_row;
	logic [NUM_WAYS-1:0][STAMP_BITS:0] wdata;
	logic [P-1:0][STAMP_BITS-1:0]      pad_stamps;

	logic [STAMP_BITS-1:0] cand_stamp_q [P];
	logic [WAY_W-1:0]      cand_idx_q [P];
	logic [LVL_W-1:0]      lvl_q;

	back_state_t      state_q;
	back_state_t      state_d;
	cmd_ctl_t         ctl_q;
	logic [SET_W-1:0] set_q;
	logic [WAY_W-1:0] way_q;
	logic [SET_W-1:0] clr_q;
	logic [STAMP_BITS-1:0] ctr_q;

	logic             rd_en;
	logic             we;
	logic [SET_W-1:0] waddr;
	logic             tree_load;
	logic             tree_step;
	logic             res_load;
	res_t             res_next;
	logic             ctr_adv;
	logic             out_free;
	logic             res_valid_q;
	res_t             res_q;

	logic [STAMP_BITS:0] ent;
	logic [STAMP_BITS:0] new_ent;
	res_t                upd_res;
	logic                upd_adv;
	logic [WX-1:0]       vict_ext;

	assign init_busy = state_q == ST_CLEAR;
	assign out_free  = !res_valid_q || res.ready;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;
	assign vict_ext  = WX'(cand_idx_q[0]);

	for (genvar g = 0; g < P; g++) begin : g_pad
		if (g < NUM_WAYS) begin : g_real
			assign pad_stamps[g] = rd_row_q[g][STAMP_BITS-1:0];
		end else begin : g_fill
			assign pad_stamps[g] = '1;
		end
	end

	always_comb begin
		ent     = rd_row_q[way_q];
		new_ent = ent;
		upd_res = '0;
		upd_adv = 1'b0;
		case (ctl_q.op)
			OP_TOUCH: begin
				if (!ctl_q.is_stream) begin
					new_ent[STAMP_BITS-1:0] = ctr_q;
					upd_adv = 1'b1;
				end else if (cfg.reuse_promote_en && ent[STAMP_BITS]) begin
					new_ent[STAMP_BITS-1:0] = ctr_q;
					upd_adv = 1'b1;
					upd_res.event_res = EV_PROMOTED;
					upd_res.promote_page = cfg.page_unlearn_en;
				end else begin
					new_ent = {1'b1, STAMP_BITS'(1)};
					upd_res.event_res = EV_DEMOTED_TOUCH;
				end
			end
			OP_FILL: begin
				upd_adv = 1'b1;
				if (cfg.fill_demote_en && ctl_q.is_stream) begin
					new_ent = {1'b0, STAMP_BITS'(1)};
					upd_res.event_res = EV_DEMOTED_FILL;
				end else begin
					new_ent = {1'b0, ctr_q};
				end
			end
			OP_INVAL: begin
				new_ent = '0;
			end
			default: begin
				new_ent = ent;
			end
		endcase
		upd_row        = rd_row_q;
		upd_row[way_q] = new_ent;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SET_W'(NUM_SETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (ctl_q.op == OP_QUERY) begin
					state_d = ST_TREE;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TREE: begin
				if (lvl_q == LVL_W'(LVLS) && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		we        = 1'b0;
		waddr     = set_q;
		wdata     = upd_row;
		tree_load = 1'b0;
		tree_step = 1'b0;
		res_load  = 1'b0;
		res_next  = '0;
		ctr_adv   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				pop   = !q_empty;
				rd_en = !q_empty;
			end
			ST_EXEC: begin
				if (ctl_q.op == OP_QUERY) begin
					tree_load = 1'b1;
				end else if (out_free) begin
					we       = ctl_q.op != OP_NOP;
					res_load = 1'b1;
					res_next = upd_res;
					ctr_adv  = upd_adv;
				end
			end
			ST_TREE: begin
				if (lvl_q != LVL_W'(LVLS)) begin
					tree_step = 1'b1;
				end else if (out_free) begin
					res_load            = 1'b1;
					res_next.victim_way = vict_ext[VICTIM_W-1:0];
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_row_q <= mem_q[q_set];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_q <= q_ctl;
			set_q <= q_set;
			way_q <= q_way;
		end
		if (res_load) begin
			res_q <= res_next;
		end
		if (tree_load) begin
			for (int i = 0; i < P; i++) begin
				cand_stamp_q[i] <= pad_stamps[i];
				cand_idx_q[i]   <= WAY_W'(i);
			end
		end else if (tree_step) begin
			for (int i = 0; i < HALF; i++) begin
				if (cand_stamp_q[2*i+1] < cand_stamp_q[2*i]) begin
					cand_stamp_q[i] <= cand_stamp_q[2*i+1];
					cand_idx_q[i]   <= cand_idx_q[2*i+1];
				end else begin
					cand_stamp_q[i] <= cand_stamp_q[2*i];
					cand_idx_q[i]   <= cand_idx_q[2*i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ctr_q       <= STAMP_BITS'(2);
			lvl_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctr_adv && ctr_q != '1) begin
				ctr_q <= ctr_q + STAMP_BITS'(1);
			end
			if (tree_load) begin
				lvl_q <= '0;
			end else if (tree_step) begin
				lvl_q <= lvl_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_ctr_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_q >= STAMP_BITS'(2))
		else $error("access counter fell below its starting value");

	a_ctr_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ctr_q >= $past(ctr_q))
		else $error("access counter moved backward");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (state_q == ST_EXEC || state_q == ST_TREE))
		else $error("result loaded outside execution");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && !q_empty))
		else $error("command popped while busy or queue empty");
`endif
endmodule

@@ rtl/stream_demote_lru_replacement.sv @@
// Top level of the stream-demoting LRU replacement block: configuration registers,
// front end, command queue and back end. Depends on sdlru_pkg, sdlru_stream_if,
// sdlru_front, sdlru_fifo and sdlru_back.
//
//   Channel  Direction  Payload                                    Transaction when
//   req      in         req_type, set_index, way, is_stream        req.valid && req.ready
//   res      out        victim_way, promote_page, event_res        res.valid && res.ready
//   cfg      in         cfg_index, cfg_wdata                       cfg_we
//
// Touch, fill and invalidate go through ST_IDLE, which reads the set's row from the set
// memory, and ST_EXEC, which updates it, writes it back and loads the result register.
// A victim query loads the pairwise minimum tree in ST_EXEC and finds the victim in ST_TREE.
// After reset the set memory is cleared one row per cycle, with req held not ready.
// A stalled result holds the back end; the queue keeps taking requests until it is full.
module stream_demote_lru_replacement #(
	parameter int NUM_SETS   = sdlru_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS   = sdlru_pkg::DEF_NUM_WAYS,
	parameter int STAMP_BITS = sdlru_pkg::DEF_STAMP_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sdlru_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sdlru_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	sdlru_stream_if.sink                       req,
	sdlru_stream_if.source                     res
);
	import sdlru_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int QW    = CTL_W + SET_W + WAY_W;

	cfg_t             cfg_q;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;
	logic             init_busy;
	cmd_ctl_t         cmd_ctl;
	logic [SET_W-1:0] cmd_set;
	logic [WAY_W-1:0] cmd_way;
	logic [QW-1:0]    q_din;
	logic [QW-1:0]    q_dout;
	cmd_ctl_t         q_ctl;
	logic [SET_W-1:0] q_set;
	logic [WAY_W-1:0] q_way;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILL_DEMOTE:   cfg_q.fill_demote_en   <= cfg_wdata[0];
				CFG_REUSE_PROMOTE: cfg_q.reuse_promote_en <= cfg_wdata[0];
				CFG_PAGE_UNLEARN:  cfg_q.page_unlearn_en  <= cfg_wdata[0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	sdlru_front #(
		.NUM_SETS (NUM_SETS),
		.NUM_WAYS (NUM_WAYS),
		.SET_W    (SET_W),
		.WAY_W    (WAY_W)
	) u_front (
		.req        (req),
		.queue_full (queue_full),
		.init_busy  (init_busy),
		.push       (push),
		.cmd_ctl    (cmd_ctl),
		.cmd_set    (cmd_set),
		.cmd_way    (cmd_way)
	);

	assign q_din = {cmd_ctl, cmd_set, cmd_way};
	assign {q_ctl, q_set, q_way} = q_dout;

	sdlru_fifo #(
		.W (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.full   (queue_full),
		.pop    (pop),
		.empty  (queue_empty),
		.dout   (q_dout)
	);

	sdlru_back #(
		.NUM_SETS   (NUM_SETS),
		.NUM_WAYS   (NUM_WAYS),
		.STAMP_BITS (STAMP_BITS),
		.SET_W      (SET_W),
		.WAY_W      (WAY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (queue_empty),
		.q_ctl     (q_ctl),
		.q_set     (q_set),
		.q_way     (q_way),
		.pop       (pop),
		.init_busy (init_busy),
		.res       (res)
	);
endmodule
